>>> src/snec_pkg.sv
// ----------------------------------------------------------------------------
// snec_pkg
// Shared types, constants and mixing functions of the node and edge counter.
// ----------------------------------------------------------------------------
package snec_pkg;

	localparam int NODE_SLOTS_DEF = 4096;
	localparam int EDGE_SLOTS_DEF = 4096;
	localparam int ADJ_KEYS_DEF   = 8192;

	localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_M1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_M2 = 64'h94d049bb133111eb;
	localparam logic [63:0] FNV_P  = 64'h00000100000001b3;
	localparam logic [63:0] GAP_MAX = 64'h000000000000ffff;

	localparam logic [3:0] K_LOAD_NODE = 4'd0;
	localparam logic [3:0] K_LOAD_EDGE = 4'd1;
	localparam logic [3:0] K_LOAD_ADJ  = 4'd2;
	localparam logic [3:0] K_READ      = 4'd3;
	localparam logic [3:0] K_OCC       = 4'd4;
	localparam logic [3:0] K_Q_NODE    = 4'd5;
	localparam logic [3:0] K_Q_EDGE    = 4'd6;
	localparam logic [3:0] K_Q_TOTAL   = 4'd7;
	localparam logic [3:0] K_CLEAR     = 4'd8;

	localparam logic [1:0] CFG_NODE = 2'd0;
	localparam logic [1:0] CFG_EDGE = 2'd1;
	localparam logic [1:0] CFG_ADJ  = 2'd2;

	typedef struct packed {
		logic [3:0]  kind;
		logic [63:0] key;
		logic [12:0] slot;
		logic [31:0] position;
		logic [31:0] read_length;
	} in_item_t;

	typedef struct packed {
		logic [63:0] value;
		logic        node_hit;
		logic [11:0] node_index;
		logic        edge_hit;
		logic [11:0] edge_index;
		logic        novel;
	} out_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic take;       // capture input item
		logic mix_start;  // start the pair-key hash
		logic clr_start;  // start count clearing sweep
		logic scan_start; // start table scans
		logic apply;      // update counts and totals, build result
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic mix_done;
		logic scan_done;
		logic clr_done;
	} sts_t;

	function automatic logic [63:0] xs30(input logic [63:0] x);
		return x ^ (x >> 30);
	endfunction

	function automatic logic [63:0] xs27(input logic [63:0] x);
		return x ^ (x >> 27);
	endfunction

	function automatic logic [63:0] xs31(input logic [63:0] x);
		return x ^ (x >> 31);
	endfunction

endpackage

>>> src/snec_ram.sv
// ----------------------------------------------------------------------------
// snec_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module snec_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> src/snec_mix.sv
// ----------------------------------------------------------------------------
// snec_mix
// Sequential pair-key hash: each 64-bit multiply is built from 32x32 partials.
// ----------------------------------------------------------------------------
module snec_mix (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] code_a,
	input  logic [63:0] code_b,
	input  logic [63:0] gap,
	output logic        done,
	output logic [63:0] result
);
	import snec_pkg::*;

	// A 64x64 low product is built from three 32x32 partials.
	logic        busy_q;
	logic [63:0] hi_q, acc_q, x_q, mb_q, g_q;
	logic [1:0]  part_q;
	logic [63:0] prod_q;
	logic [63:0] pp;
	logic [31:0] ma, mb;

	// multiply sequence: mul op (x_q * mb_q) in part_q 0..2, then next op
	always_comb begin
		case (part_q)
			2'd0:    begin ma = x_q[31:0];  mb = mb_q[31:0];  end
			2'd1:    begin ma = x_q[63:32]; mb = mb_q[31:0];  end
			default: begin ma = x_q[31:0];  mb = mb_q[63:32]; end
		endcase
		pp = 64'(ma) * 64'(mb);
	end

	// ops: 0 lo m1,1 lo m2,2 hi m1,3 hi m2,4 hi*FNV,5 g*GOLD,6 k m1,7 k m2
	logic [2:0]  op_q;
	logic [63:0] prod_full;
	assign prod_full = (part_q == 2'd0) ? pp :
		prod_q + {pp[31:0], 32'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			part_q <= 2'd0;
			op_q   <= 3'd0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				part_q <= 2'd0;
				op_q   <= 3'd0;
				hi_q   <= (code_a < code_b) ? code_b : code_a;
				g_q    <= (gap > GAP_MAX) ? GAP_MAX : gap;
				x_q    <= xs30(((code_a < code_b) ? code_a : code_b) + GOLDEN);
				mb_q   <= MIX_M1;
			end else if (busy_q) begin
				if (part_q != 2'd2) begin
					prod_q <= prod_full;
					part_q <= part_q + 2'd1;
				end else begin
					part_q <= 2'd0;
					op_q   <= op_q + 3'd1;
					case (op_q)
						3'd0: begin x_q <= xs27(prod_full); mb_q <= MIX_M2; end
						3'd1: begin
							acc_q <= xs31(prod_full);
							x_q   <= xs30(hi_q + GOLDEN);
							mb_q  <= MIX_M1;
						end
						3'd2: begin x_q <= xs27(prod_full); mb_q <= MIX_M2; end
						3'd3: begin x_q <= xs31(prod_full); mb_q <= FNV_P; end
						3'd4: begin
							acc_q <= acc_q ^ prod_full;
							x_q   <= g_q;
							mb_q  <= GOLDEN;
						end
						3'd5: begin
							x_q  <= xs30((acc_q ^ prod_full) + GOLDEN);
							mb_q <= MIX_M1;
						end
						3'd6: begin x_q <= xs27(prod_full); mb_q <= MIX_M2; end
						default: begin
							result <= xs31(prod_full);
							busy_q <= 1'b0;
							done   <= 1'b1;
						end
					endcase
				end
			end
		end
	end
endmodule

>>> src/snec_datapath.sv
// ----------------------------------------------------------------------------
// snec_datapath
// Tables, scans, counters, totals and result register.
// ----------------------------------------------------------------------------
module snec_datapath #(
	parameter int NODE_SLOTS = 4096,
	parameter int EDGE_SLOTS = 4096,
	parameter int ADJ_KEYS   = 8192
) (
	input  logic                clk,
	input  logic                arst_n,
	input  snec_pkg::in_item_t  in_item,
	input  snec_pkg::cmd_t      cmd,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [31:0]         cfg_data,
	output snec_pkg::sts_t      sts,
	output snec_pkg::out_item_t res,
	output logic [3:0]          kind
);
	import snec_pkg::*;

	localparam int NW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
	localparam int EW = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
	localparam int AW = (ADJ_KEYS > 1) ? $clog2(ADJ_KEYS) : 1;
	localparam int NND = 1 << NW;
	localparam int END = 1 << EW;
	localparam int AND_D = 1 << AW;
	localparam int CW = (AW > NW ? (AW > EW ? AW : EW) : (NW > EW ? NW : EW)) + 1;

	in_item_t    it_q;
	logic [12:0] node_n_q, edge_n_q;
	logic [13:0] adj_n_q;
	logic [63:0] prev_code_q;
	logic [31:0] prev_pos_q;
	logic        have_prev_q;
	logic [63:0] tot_q [5];

	assign kind = it_q.kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_n_q <= '0;
			edge_n_q <= '0;
			adj_n_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_NODE: node_n_q <= cfg_data[12:0];
				CFG_EDGE: edge_n_q <= cfg_data[12:0];
				CFG_ADJ:  adj_n_q  <= cfg_data[13:0];
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) it_q <= in_item;
	end

	// search limits, saturated at table size
	logic [CW-1:0] nlim, elim, alim;
	assign nlim = (CW'(node_n_q) > CW'(NODE_SLOTS)) ? CW'(NODE_SLOTS) : CW'(node_n_q);
	assign elim = (CW'(edge_n_q) > CW'(EDGE_SLOTS)) ? CW'(EDGE_SLOTS) : CW'(edge_n_q);
	assign alim = (CW'(adj_n_q) > CW'(ADJ_KEYS)) ? CW'(ADJ_KEYS) : CW'(adj_n_q);

	// pair hash
	logic [63:0] akey;
	logic        mix_done;
	snec_mix u_mix (
		.clk(clk), .arst_n(arst_n), .start(cmd.mix_start),
		.code_a(prev_code_q), .code_b(it_q.key),
		.gap(64'(it_q.position) - 64'(prev_pos_q)),
		.done(mix_done), .result(akey)
	);
	logic mix_done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mix_done_q <= 1'b0;
		else if (cmd.take || cmd.mix_start) mix_done_q <= 1'b0;
		else if (mix_done) mix_done_q <= 1'b1;
	end

	// scan: one address per cycle into each key RAM, compared in the cycle after
	logic          scan_q, cmp_q;
	logic [CW-1:0] sidx_q, cidx_q;
	logic          nfound_q, efound_q, afound_q;
	logic [NW-1:0] nhit_q;
	logic [EW-1:0] ehit_q;
	logic [63:0]   nk_rd, ek_rd, ak_rd;

	snec_ram #(.WIDTH(64), .DEPTH(NND)) u_nkey (
		.clk(clk), .we(cmd.take && in_item.kind == K_LOAD_NODE &&
			32'(in_item.slot) < 32'(NODE_SLOTS)),
		.waddr(in_item.slot[NW-1:0]), .wdata(in_item.key),
		.raddr(sidx_q[NW-1:0]), .rdata(nk_rd));
	snec_ram #(.WIDTH(64), .DEPTH(END)) u_ekey (
		.clk(clk), .we(cmd.take && in_item.kind == K_LOAD_EDGE &&
			32'(in_item.slot) < 32'(EDGE_SLOTS)),
		.waddr(in_item.slot[EW-1:0]), .wdata(in_item.key),
		.raddr(sidx_q[EW-1:0]), .rdata(ek_rd));
	snec_ram #(.WIDTH(64), .DEPTH(AND_D)) u_akey (
		.clk(clk), .we(cmd.take && in_item.kind == K_LOAD_ADJ &&
			32'(in_item.slot) < 32'(ADJ_KEYS)),
		.waddr(in_item.slot[AW-1:0]), .wdata(in_item.key),
		.raddr(sidx_q[AW-1:0]), .rdata(ak_rd));

	logic [CW-1:0] smax;
	assign smax = (nlim > elim) ? ((nlim > alim) ? nlim : alim) :
		((elim > alim) ? elim : alim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= 1'b0;
			cmp_q  <= 1'b0;
		end else if (cmd.scan_start) begin
			scan_q   <= 1'b1;
			cmp_q    <= 1'b0;
			sidx_q   <= '0;
			nfound_q <= 1'b0;
			efound_q <= 1'b0;
			afound_q <= 1'b0;
			nhit_q   <= '0;
			ehit_q   <= '0;
		end else begin
			cmp_q  <= scan_q && sidx_q < smax;
			cidx_q <= sidx_q;
			if (scan_q) begin
				if (sidx_q < smax) sidx_q <= sidx_q + CW'(1);
				else scan_q <= 1'b0;
			end
			if (cmp_q) begin
				if (!nfound_q && cidx_q < nlim && nk_rd == it_q.key) begin
					nfound_q <= 1'b1;
					nhit_q   <= cidx_q[NW-1:0];
				end
				if (!efound_q && have_prev_q && cidx_q < elim && ek_rd == akey) begin
					efound_q <= 1'b1;
					ehit_q   <= cidx_q[EW-1:0];
				end
				if (cidx_q < alim && ak_rd == akey) afound_q <= 1'b1;
			end
		end
	end
	assign sts.scan_done = !scan_q && !cmp_q;
	assign sts.mix_done  = mix_done_q || !have_prev_q;

	// count RAMs: read-modify-write, cleared by sweep
	logic          clr_q;
	logic [CW-1:0] cidx_clr_q;
	logic [31:0]   nc_rd, ec_rd;
	logic [NW-1:0] nc_addr;
	logic [EW-1:0] ec_addr;
	logic          nc_we, ec_we;
	logic [31:0]   nc_wd, ec_wd;

	always_comb begin
		nc_addr = (it_q.kind == K_OCC) ? nhit_q : it_q.slot[NW-1:0];
		ec_addr = (it_q.kind == K_OCC) ? ehit_q : it_q.slot[EW-1:0];
		nc_we = 1'b0; ec_we = 1'b0;
		nc_wd = nc_rd + 32'd1; ec_wd = ec_rd + 32'd1;
		if (clr_q) begin
			nc_addr = cidx_clr_q[NW-1:0];
			ec_addr = cidx_clr_q[EW-1:0];
			nc_we = cidx_clr_q < CW'(NODE_SLOTS);
			ec_we = cidx_clr_q < CW'(EDGE_SLOTS);
			nc_wd = '0; ec_wd = '0;
		end else if (cmd.apply && it_q.kind == K_OCC) begin
			nc_we = nfound_q;
			ec_we = efound_q;
		end
	end

	// the read at the apply step uses the hit slot, or the queried slot
	logic [31:0] nc_mem, ec_mem;
	snec_ram #(.WIDTH(32), .DEPTH(NND)) u_ncnt (
		.clk(clk), .we(nc_we), .waddr(nc_addr), .wdata(nc_wd),
		.raddr(nc_addr), .rdata(nc_mem));
	snec_ram #(.WIDTH(32), .DEPTH(END)) u_ecnt (
		.clk(clk), .we(ec_we), .waddr(ec_addr), .wdata(ec_wd),
		.raddr(ec_addr), .rdata(ec_mem));
	assign nc_rd = nc_mem;
	assign ec_rd = ec_mem;

	logic [CW-1:0] cmax;
	assign cmax = (NODE_SLOTS > EDGE_SLOTS) ? CW'(NODE_SLOTS) : CW'(EDGE_SLOTS);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			cidx_clr_q <= '0;
		end else if (cmd.clr_start) begin
			clr_q      <= 1'b1;
			cidx_clr_q <= '0;
		end else if (clr_q) begin
			if (cidx_clr_q + CW'(1) >= cmax) clr_q <= 1'b0;
			cidx_clr_q <= cidx_clr_q + CW'(1);
		end
	end
	assign sts.clr_done = !clr_q;

	// totals, history and result
	logic nov;
	assign nov = have_prev_q && adj_n_q != '0 && !afound_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) tot_q[i] <= '0;
			prev_code_q <= '0;
			prev_pos_q  <= '0;
			have_prev_q <= 1'b0;
		end else if (cmd.clr_start) begin
			for (int i = 0; i < 5; i++) tot_q[i] <= '0;
			prev_code_q <= '0;
			prev_pos_q  <= '0;
			have_prev_q <= 1'b0;
		end else if (cmd.apply) begin
			if (it_q.kind == K_READ) begin
				tot_q[0]    <= tot_q[0] + 64'd1;
				tot_q[1]    <= tot_q[1] + 64'(it_q.read_length);
				have_prev_q <= 1'b0;
			end else if (it_q.kind == K_OCC) begin
				tot_q[2] <= tot_q[2] + 64'd1;
				if (nfound_q) tot_q[3] <= tot_q[3] + 64'd1;
				if (nov) tot_q[4] <= tot_q[4] + 64'd1;
				prev_code_q <= it_q.key;
				prev_pos_q  <= it_q.position;
				have_prev_q <= 1'b1;
			end
		end
	end

	out_item_t res_d;
	always_comb begin
		res_d = '0;
		case (it_q.kind)
			K_OCC: begin
				res_d.node_hit   = nfound_q;
				res_d.node_index = nfound_q ? 12'(nhit_q) : 12'd0;
				if (have_prev_q) begin
					res_d.value      = akey;
					res_d.edge_hit   = efound_q;
					res_d.edge_index = efound_q ? 12'(ehit_q) : 12'd0;
					res_d.novel      = nov;
				end
			end
			K_Q_NODE:
				if (32'(it_q.slot) < 32'(NODE_SLOTS)) res_d.value = 64'(nc_rd);
			K_Q_EDGE:
				if (32'(it_q.slot) < 32'(EDGE_SLOTS)) res_d.value = 64'(ec_rd);
			K_Q_TOTAL:
				if (it_q.slot < 13'd5) res_d.value = tot_q[it_q.slot[2:0]];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) res <= res_d;
	end
endmodule

>>> src/snec_ctrl.sv
// ----------------------------------------------------------------------------
// snec_ctrl
// Sequencer for one request at a time and the output handshake.
// ----------------------------------------------------------------------------
module snec_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  logic [3:0]     kind,
	input  snec_pkg::sts_t sts,
	output snec_pkg::cmd_t cmd
);
	import snec_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_WAIT  = 3'd2;
	localparam logic [2:0] S_APPLY = 3'd3;
	localparam logic [2:0] S_HOLD  = 3'd4;
	localparam logic [2:0] S_CLR   = 3'd5;
	localparam logic [2:0] S_MIX   = 3'd6;

	logic [2:0] state_q;
	logic       ovalid_q;

	assign in_ready  = state_q == S_IDLE && sts.clr_done && (!ovalid_q || out_ready);
	assign out_valid = ovalid_q;

	always_comb begin
		cmd = '0;
		cmd.take = in_valid && in_ready;
		case (state_q)
			S_START: begin
				cmd.mix_start = kind == K_OCC;
				cmd.clr_start = kind == K_CLEAR;
			end
			// scan only once the pair key is ready
			S_MIX:   cmd.scan_start = sts.mix_done;
			S_APPLY: cmd.apply = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (state_q == S_HOLD) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE:  if (cmd.take) state_q <= S_START;
				S_START: state_q <= (kind == K_CLEAR) ? S_CLR :
					(kind == K_OCC) ? S_MIX : S_WAIT;
				S_MIX:   if (sts.mix_done) state_q <= S_WAIT;
				S_CLR:   if (sts.clr_done) state_q <= S_APPLY;
				S_WAIT:  if (sts.scan_done) state_q <= S_APPLY;
				S_APPLY: state_q <= S_HOLD;
				S_HOLD:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	ap_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> !in_ready) else $error("second request taken");
	ap_apply_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> ##1 out_valid) else $error("no result after apply");
endmodule

>>> src/syncmer_node_edge_counter_top.sv
// ----------------------------------------------------------------------------
// syncmer_node_edge_counter_top
// Node and adjacency counter for k-mer occurrences.
// ----------------------------------------------------------------------------
// Usage: requests enter on in_valid/in_ready with a kind code; each request
// returns exactly one result on out_valid/out_ready. Registers are written
// on cfg_valid/cfg_ready; the user must do so only while idle, which the
// block does not enforce. One request is in flight at a time. Loads, queries
// and read starts pass through the start, wait, apply and hold states. An
// occurrence scans the key tables one slot per cycle through one address
// shared by the node, edge and panel key RAMs, up to the largest saturated
// search length in use. When a previous occurrence exists, the pair-key hash
// (eight 64-bit multiplies, each three 32x32 partial products) runs first,
// since the edge and panel scans compare against its result. Clear sweeps
// the count RAMs, one entry a cycle. After reset the same sweep runs and
// in_ready stays low for its length. A stalled receiver holds the result;
// the next request is taken once the result register is being emptied.
// ----------------------------------------------------------------------------
module syncmer_node_edge_counter_top #(
	parameter int NODE_SLOTS = snec_pkg::NODE_SLOTS_DEF,
	parameter int EDGE_SLOTS = snec_pkg::EDGE_SLOTS_DEF,
	parameter int ADJ_KEYS   = snec_pkg::ADJ_KEYS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  snec_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output snec_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_value
);
	import snec_pkg::*;

	cmd_t       cmd;
	sts_t       sts;
	logic [3:0] kind;

	assign cfg_ready = 1'b1;

	snec_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .kind(kind),
		.sts(sts), .cmd(cmd)
	);

	snec_datapath #(
		.NODE_SLOTS(NODE_SLOTS), .EDGE_SLOTS(EDGE_SLOTS), .ADJ_KEYS(ADJ_KEYS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .cmd(cmd),
		.cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_data(cfg_value),
		.sts(sts), .res(out_data), .kind(kind)
	);
endmodule

>>> verif/syncmer_node_edge_counter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// syncmer_node_edge_counter_top_tb
// Self-checking bench: drives load, read, occurrence, query and clear
// requests with random idling on both channels, predicts each result with a
// local copy of the tables and totals, and compares result fields in order.
// ----------------------------------------------------------------------------
module syncmer_node_edge_counter_top_tb;
	import snec_pkg::*;

	localparam logic [1:0] CFG_NONE  = 2'd3;
	localparam logic [3:0] K_UNUSED_LO = 4'd9;
	localparam logic [3:0] K_UNUSED_HI = 4'd15;
	localparam int N_CAP = 4096;
	localparam int E_CAP = 4096;
	localparam int A_CAP = 8192;
	localparam int POOL = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_value = '0;

	syncmer_node_edge_counter_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_value(cfg_value)
	);

	always #5 clk = ~clk;

	// local copy of the block state
	logic [63:0] node_keys [N_CAP];
	logic [31:0] node_counts [N_CAP];
	bit          node_loaded [N_CAP];
	logic [63:0] edge_key_mem [E_CAP];
	logic [31:0] edge_counts [E_CAP];
	bit          edge_loaded [E_CAP];
	logic [63:0] panel_keys [A_CAP];
	bit          panel_loaded [A_CAP];
	logic [63:0] totals [5];
	logic [63:0] last_code;
	logic [31:0] last_pos;
	bit          have_last;
	int unsigned node_limit, edge_limit, panel_limit;

	out_item_t   pending_results [$];
	int          mismatches = 0;
	bit          idling = 1'b1;
	logic [63:0] code_pool [POOL];
	logic [31:0] cur_pos = 0;

	function automatic logic [63:0] splitmix(input logic [63:0] x);
		logic [63:0] y;
		y = x + GOLDEN;
		y = (y ^ (y >> 30)) * MIX_M1;
		y = (y ^ (y >> 27)) * MIX_M2;
		return y ^ (y >> 31);
	endfunction

	function automatic logic [63:0] link_hash(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] gap);
		logic [63:0] lo, hi, g;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		g = (gap > GAP_MAX) ? GAP_MAX : gap;
		return splitmix(splitmix(lo) ^ (splitmix(hi) * FNV_P) ^ (g * GOLDEN));
	endfunction

	function automatic int find_key(input int kind_sel, input int unsigned n, input logic [63:0] k);
		int lim;
		lim = (kind_sel == 0) ? ((n < N_CAP) ? n : N_CAP) :
			(kind_sel == 1) ? ((n < E_CAP) ? n : E_CAP) : ((n < A_CAP) ? n : A_CAP);
		for (int i = 0; i < lim; i++) begin
			if ((kind_sel == 0 && node_keys[i] == k) || (kind_sel == 1 && edge_key_mem[i] == k) ||
					(kind_sel == 2 && panel_keys[i] == k))
				return i;
		end
		return -1;
	endfunction

	function automatic void count_model(input in_item_t it, output out_item_t r);
		int n, e;
		logic [63:0] ak;
		r = '0;
		case (it.kind)
			K_LOAD_NODE: if (it.slot < N_CAP) begin
				node_keys[it.slot] = it.key;
				node_loaded[it.slot] = 1'b1;
			end
			K_LOAD_EDGE: if (it.slot < E_CAP) begin
				edge_key_mem[it.slot] = it.key;
				edge_loaded[it.slot] = 1'b1;
			end
			K_LOAD_ADJ: if (it.slot < A_CAP) begin
				panel_keys[it.slot] = it.key;
				panel_loaded[it.slot] = 1'b1;
			end
			K_READ: begin
				totals[0] += 1;
				totals[1] += {32'b0, it.read_length};
				have_last = 1'b0;
			end
			K_OCC: begin
				n = find_key(0, node_limit, it.key);
				totals[2] += 1;
				if (n >= 0) begin
					node_counts[n] += 1;
					totals[3] += 1;
					r.node_hit = 1'b1;
					r.node_index = n[11:0];
				end
				if (have_last) begin
					ak = link_hash(last_code, it.key, {32'b0, it.position} - {32'b0, last_pos});
					r.value = ak;
					e = find_key(1, edge_limit, ak);
					if (e >= 0) begin
						edge_counts[e] += 1;
						r.edge_hit = 1'b1;
						r.edge_index = e[11:0];
					end
					if (panel_limit != 0 && find_key(2, panel_limit, ak) < 0) begin
						totals[4] += 1;
						r.novel = 1'b1;
					end
				end
				last_code = it.key;
				last_pos = it.position;
				have_last = 1'b1;
			end
			K_Q_NODE: if (it.slot < N_CAP) r.value = {32'b0, node_counts[it.slot]};
			K_Q_EDGE: if (it.slot < E_CAP) r.value = {32'b0, edge_counts[it.slot]};
			K_Q_TOTAL: if (it.slot < 5) r.value = totals[it.slot];
			K_CLEAR: begin
				foreach (node_counts[i]) node_counts[i] = '0;
				foreach (edge_counts[i]) edge_counts[i] = '0;
				foreach (totals[i]) totals[i] = '0;
				last_code = '0;
				last_pos = '0;
				have_last = 1'b0;
			end
			default: ;
		endcase
	endfunction

	// hold valid across back-to-back requests; drop it only for a gap
	task automatic send_request(input in_item_t it, input bit zero_result);
		out_item_t r;
		if (idling && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		count_model(it, r);
		pending_results.insert(pending_results.size(), zero_result ? out_item_t'('0) : r);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_value <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_NODE: node_limit = val[12:0];
			CFG_EDGE: edge_limit = val[12:0];
			CFG_ADJ:  panel_limit = val[13:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [63:0] pool_pair_key;
		return link_hash(code_pool[$urandom_range(0, POOL - 1)],
			code_pool[$urandom_range(0, POOL - 1)], 64'($urandom_range(0, 4)));
	endfunction

	function automatic in_item_t make_item(input logic [3:0] k, input logic [63:0] key,
			input logic [12:0] slot);
		in_item_t it;
		it = '0;
		it.kind = k;
		it.key = key;
		it.slot = slot;
		it.position = $urandom;
		it.read_length = $urandom;
		return it;
	endfunction

	// fill every slot a search may reach before the register allows it
	task automatic fill_tables(input int unsigned nn, input int unsigned ne, input int unsigned na);
		for (int i = 0; i < nn && i < N_CAP; i++)
			if (!node_loaded[i])
				send_request(make_item(K_LOAD_NODE, code_pool[$urandom_range(0, POOL - 1)],
					13'(i)), 1'b0);
		for (int i = 0; i < ne && i < E_CAP; i++)
			if (!edge_loaded[i])
				send_request(make_item(K_LOAD_EDGE, ($urandom_range(0, 3) != 0) ?
					pool_pair_key() : {$urandom, $urandom}, 13'(i)), 1'b0);
		for (int i = 0; i < na && i < A_CAP; i++)
			if (!panel_loaded[i])
				send_request(make_item(K_LOAD_ADJ, ($urandom_range(0, 3) != 0) ?
					pool_pair_key() : {$urandom, $urandom}, 13'(i)), 1'b0);
	endtask

	task automatic configure(input int unsigned nn, input int unsigned ne, input int unsigned na);
		fill_tables(nn, ne, na);
		drain();
		write_reg(CFG_NODE, ($urandom & 32'hffff_e000) | nn);
		write_reg(CFG_EDGE, ($urandom & 32'hffff_e000) | ne);
		write_reg(CFG_ADJ, ($urandom & 32'hffff_c000) | na);
	endtask

	function automatic in_item_t random_item;
		in_item_t it;
		int unsigned r;
		logic [12:0] s;
		r = $urandom_range(0, 99);
		s = ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 48));
		it = make_item(K_Q_NODE, {$urandom, $urandom}, s);
		if (r < 6) begin
			it.kind = K_READ;
			cur_pos = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 100);
		end else if (r < 62) begin
			it.kind = K_OCC;
			if ($urandom_range(0, 4) != 0) it.key = code_pool[$urandom_range(0, POOL - 1)];
			if ($urandom_range(0, 19) == 0) cur_pos = $urandom;
			else cur_pos = cur_pos + $urandom_range(0, 4);
			it.position = cur_pos;
		end else if (r < 66) begin
			it.kind = K_LOAD_NODE;
			if ($urandom_range(0, 2) != 0) it.key = code_pool[$urandom_range(0, POOL - 1)];
		end else if (r < 70) begin
			it.kind = K_LOAD_EDGE;
			if ($urandom_range(0, 2) != 0) it.key = pool_pair_key();
		end else if (r < 74) begin
			it.kind = K_LOAD_ADJ;
			if ($urandom_range(0, 2) != 0) it.key = pool_pair_key();
		end else if (r < 84) begin
			it.kind = K_Q_NODE;
		end else if (r < 90) begin
			it.kind = K_Q_EDGE;
		end else if (r < 96) begin
			it.kind = K_Q_TOTAL;
			it.slot = $urandom_range(0, 6);
		end else if (r < 98) begin
			it.kind = K_CLEAR;
		end else begin
			it.kind = 4'($urandom_range(K_UNUSED_LO, K_UNUSED_HI));
		end
		return it;
	endfunction

	typedef struct {
		logic [3:0]  kind;
		logic [63:0] key;
		logic [12:0] slot;
		logic [31:0] position;
		logic [31:0] read_length;
		bit          zero;
	} row_t;

	row_t opening_rows [] = '{
		'{K_Q_TOTAL,   64'h0, 13'd0,    32'h0, 32'h0, 1'b1},
		'{K_Q_NODE,    64'h0, 13'd4095, 32'h0, 32'h0, 1'b1},
		'{K_Q_EDGE,    64'h0, 13'd8191, 32'h0, 32'h0, 1'b1},
		'{K_Q_TOTAL,   64'h0, 13'd5,    32'h0, 32'h0, 1'b1},
		'{K_Q_TOTAL,   64'h0, 13'd8191, 32'h0, 32'h0, 1'b1},
		// occurrence before any read start: first, so no adjacency
		'{K_OCC, 64'hffff_ffff_ffff_ffff, 13'd0, 32'h0, 32'h0, 1'b1},
		'{K_OCC, 64'h0, 13'd8191, 32'hffff_ffff, 32'hffff_ffff, 1'b0},
		// backward step: wrapped gap clamps
		'{K_OCC, 64'h1, 13'd0, 32'h0, 32'h0, 1'b0},
		'{K_OCC, 64'h1, 13'd0, 32'h0, 32'h0, 1'b0},
		'{K_READ, 64'h0, 13'd0, 32'h0, 32'hffff_ffff, 1'b1},
		'{K_OCC, 64'h8000_0000_0000_0000, 13'd0, 32'h5, 32'h0, 1'b1},
		'{K_LOAD_NODE, 64'h1234_5678_9abc_def0, 13'd8191, 32'h0, 32'h0, 1'b1},
		'{K_LOAD_NODE, 64'hffff_ffff_ffff_ffff, 13'd0, 32'h0, 32'h0, 1'b1},
		'{K_LOAD_EDGE, 64'hffff_ffff_ffff_ffff, 13'd4095, 32'h0, 32'h0, 1'b1},
		'{K_LOAD_EDGE, 64'h0, 13'd4096, 32'h0, 32'h0, 1'b1},
		'{K_LOAD_ADJ,  64'hffff_ffff_ffff_ffff, 13'd8191, 32'h0, 32'h0, 1'b1},
		'{K_LOAD_ADJ,  64'h0, 13'd0, 32'h0, 32'h0, 1'b1},
		'{K_UNUSED_LO, 64'hffff_ffff_ffff_ffff, 13'd3, 32'h7, 32'h9, 1'b1},
		'{K_UNUSED_HI, 64'hffff_ffff_ffff_ffff, 13'd8191, 32'hffff_ffff, 32'hffff_ffff, 1'b1},
		'{K_Q_TOTAL, 64'h0, 13'd1, 32'h0, 32'h0, 1'b0},
		'{K_Q_TOTAL, 64'h0, 13'd2, 32'h0, 32'h0, 1'b0},
		'{K_Q_TOTAL, 64'h0, 13'd4, 32'h0, 32'h0, 1'b1},
		'{K_CLEAR, 64'h0, 13'd0, 32'h0, 32'h0, 1'b1},
		'{K_Q_TOTAL, 64'h0, 13'd2, 32'h0, 32'h0, 1'b1}
	};

	// result side: random stall bursts, compare against oldest expectation
	initial begin
		int unsigned burst;
		bit stall;
		out_item_t want;
		burst = 0;
		stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %p at %0t", out_data, $realtime);
				end else begin
					want = pending_results.pop_front();
					if (out_data.value !== want.value || out_data.node_hit !== want.node_hit ||
							out_data.node_index !== want.node_index ||
							out_data.edge_hit !== want.edge_hit ||
							out_data.edge_index !== want.edge_index ||
							out_data.novel !== want.novel) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch at %0t: expected %p got %p", $realtime, want,
								out_data);
					end
				end
			end
			if (burst == 0) begin
				stall = idling && $urandom_range(0, 3) == 0;
				burst = $urandom_range(1, 16);
			end
			burst--;
			out_ready <= !(stall && idling);
		end
	end

	initial begin
		#30_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		in_item_t it;
		foreach (node_counts[i]) begin
			node_counts[i] = '0;
			node_loaded[i] = 1'b0;
		end
		foreach (edge_counts[i]) begin
			edge_counts[i] = '0;
			edge_loaded[i] = 1'b0;
		end
		foreach (panel_loaded[i]) panel_loaded[i] = 1'b0;
		foreach (totals[i]) totals[i] = '0;
		last_code = '0;
		last_pos = '0;
		have_last = 1'b0;
		node_limit = 0;
		edge_limit = 0;
		panel_limit = 0;
		code_pool[0] = '0;
		code_pool[1] = '1;
		for (int i = 2; i < POOL; i++) code_pool[i] = {$urandom, $urandom};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_rows[i]) begin
			it.kind = opening_rows[i].kind;
			it.key = opening_rows[i].key;
			it.slot = opening_rows[i].slot;
			it.position = opening_rows[i].position;
			it.read_length = opening_rows[i].read_length;
			send_request(it, opening_rows[i].zero);
		end
		drain();
		write_reg(CFG_NONE, 32'hffff_ffff);

		for (int ph = 0; ph < 11; ph++) begin
			idling = (ph != 4);
			case (ph)
				0: configure(0, 0, 0);
				1: configure(1, 1, 1);
				default: configure($urandom_range(0, 40), $urandom_range(0, 40),
					$urandom_range(0, 40));
			endcase
			repeat (130) send_request(random_item(), 1'b0);
			drain();
		end

		// last part: no idling, longest searches of the run
		idling = 1'b0;
		configure(48, 48, 48);
		repeat (30) send_request(random_item(), 1'b0);
		for (int i = 0; i < 5; i++)
			send_request(make_item(K_Q_TOTAL, '0, 13'(i)), 1'b0);
		send_request(make_item(K_Q_NODE, '0, 13'd4095), 1'b0);
		send_request(make_item(K_CLEAR, '0, 13'd0), 1'b0);
		send_request(make_item(K_Q_TOTAL, '0, 13'd2), 1'b0);
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
